// ----- design/utf8_sanitizer_with_budget_macros.svh -----
// assertion macros shared by the utf8 sanitiser modules
`ifndef UTF8_SANITIZER_WITH_BUDGET_MACROS_SVH
`define UTF8_SANITIZER_WITH_BUDGET_MACROS_SVH

// condition holds on every clock edge outside reset
`define U8S_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// consequent holds in the same cycle as the antecedent
`define U8S_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define U8S_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/u8s_pkg.sv -----
// shared constants and types of the utf8 sanitiser
package u8s_pkg;

   localparam int ByteWidth  = 8;
   localparam int QDepth     = 4;
   localparam int HeldDepth  = 3;
   localparam int MaxResults = 12;
   localparam int CountWidth = $clog2(MaxResults + 1);
   localparam int CfgWidth   = 17;
   localparam int CpWidth    = 21;

   localparam logic [CfgWidth-1:0] BudgetReset = 17'h10000;

   localparam logic [ByteWidth-1:0] ReplByte0 = 8'hEF;
   localparam logic [ByteWidth-1:0] ReplByte1 = 8'hBF;
   localparam logic [ByteWidth-1:0] ReplByte2 = 8'hBD;

   localparam logic [ByteWidth-1:0] AsciiLimit = 8'h80;
   localparam logic [ByteWidth-1:0] Lead2Mask  = 8'hE0;
   localparam logic [ByteWidth-1:0] Lead2Code  = 8'hC0;
   localparam logic [ByteWidth-1:0] Lead3Mask  = 8'hF0;
   localparam logic [ByteWidth-1:0] Lead3Code  = 8'hE0;
   localparam logic [ByteWidth-1:0] Lead4Mask  = 8'hF8;
   localparam logic [ByteWidth-1:0] Lead4Code  = 8'hF0;
   localparam logic [ByteWidth-1:0] ContMask   = 8'hC0;
   localparam logic [ByteWidth-1:0] ContCode   = 8'h80;

   localparam logic [CpWidth-1:0] CpMin2   = 21'h00080;
   localparam logic [CpWidth-1:0] CpMin3   = 21'h00800;
   localparam logic [CpWidth-1:0] CpMin4   = 21'h10000;
   localparam logic [CpWidth-1:0] CpMax    = 21'h10FFFF;
   localparam logic [CpWidth-1:0] SurrLow  = 21'h0D800;
   localparam logic [CpWidth-1:0] SurrHigh = 21'h0DFFF;

   typedef enum logic [1:0] {
      JUDGE_ASCII,
      JUDGE_REPL,
      JUDGE_SEQ,
      JUDGE_HOLD
   } judge_kind_type;

   typedef struct packed {
      judge_kind_type kind;
      logic [2:0]     len;
   } judge_type;

   typedef logic [MaxResults-1:0][ByteWidth-1:0] byte_list_type;

   typedef struct packed {
      byte_list_type         bytes;
      logic [CountWidth-1:0] count;
      logic                  present;
      logic                  last;
   } load_type;

endpackage

// ----- design/u8s_ifs.sv -----
// valid/ready channel interfaces of the utf8 sanitiser
interface u8s_req_if;
   import u8s_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] in_byte;
   logic                 last_of_string;
   modport source (output valid, in_byte, last_of_string, input ready);
   modport sink   (input valid, in_byte, last_of_string, output ready);
endinterface

interface u8s_rsp_if;
   import u8s_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] out_byte;
   logic                 byte_present;
   logic                 run_end;
   logic                 string_done;
   modport source (output valid, out_byte, byte_present, run_end, string_done, input ready);
   modport sink   (input valid, out_byte, byte_present, run_end, string_done, output ready);
endinterface

interface u8s_csr_if;
   import u8s_pkg::*;
   logic                valid;
   logic                ready;
   logic [CfgWidth-1:0] max_output_bytes;
   modport source (output valid, max_output_bytes, input ready);
   modport sink   (input valid, max_output_bytes, output ready);
endinterface

// ----- design/u8s_judge.sv -----
// judges one utf8 sequence that starts at a given queue position
module u8s_judge (
   input  logic [u8s_pkg::QDepth-1:0][u8s_pkg::ByteWidth-1:0] win,
   input  logic [2:0]                                         avail,
   input  logic                                               last,
   output u8s_pkg::judge_type                                 jd
);
   import u8s_pkg::*;

   logic [ByteWidth-1:0] lead;
   logic [2:0]           size;
   logic [2:0]           have;
   logic                 bad_cont;
   logic                 range_bad;
   logic [CpWidth-1:0]   cp;
   logic [CpWidth-1:0]   cp_min;

   always_comb begin
      lead = win[0];
      if ((lead & Lead2Mask) == Lead2Code) begin
         size = 3'd2;
      end else if ((lead & Lead3Mask) == Lead3Code) begin
         size = 3'd3;
      end else if ((lead & Lead4Mask) == Lead4Code) begin
         size = 3'd4;
      end else begin
         size = 3'd0;
      end

      have = (avail < size) ? avail : size;

      bad_cont = 1'b0;
      for (int i = 1; i < QDepth; i++) begin
         if ((3'(i) < have) && ((win[i] & ContMask) != ContCode)) begin
            bad_cont = 1'b1;
         end
      end

      case (size)
         3'd2: begin
            cp     = {10'd0, lead[4:0], win[1][5:0]};
            cp_min = CpMin2;
         end
         3'd3: begin
            cp     = {5'd0, lead[3:0], win[1][5:0], win[2][5:0]};
            cp_min = CpMin3;
         end
         3'd4: begin
            cp     = {lead[2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
            cp_min = CpMin4;
         end
         default: begin
            cp     = '0;
            cp_min = '0;
         end
      endcase

      range_bad = (cp < cp_min) || (cp > CpMax) || ((cp >= SurrLow) && (cp <= SurrHigh));

      jd.len = size;
      if (lead == '0) begin
         jd.kind = JUDGE_REPL;
      end else if (lead < AsciiLimit) begin
         jd.kind = JUDGE_ASCII;
      end else if (size == 3'd0 || bad_cont) begin
         jd.kind = JUDGE_REPL;
      end else if (have < size) begin
         jd.kind = last ? JUDGE_REPL : JUDGE_HOLD;
      end else if (range_bad) begin
         jd.kind = JUDGE_REPL;
      end else begin
         jd.kind = JUDGE_SEQ;
      end
   end

endmodule

// ----- design/u8s_out_buf.sv -----
// result buffer: holds the bytes of one item and hands them out one a cycle while rsp ready is high
`include "utf8_sanitizer_with_budget_macros.svh"

module u8s_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              ld_valid,
   input  u8s_pkg::load_type ld,
   output logic              free,
   u8s_rsp_if.source         rsp_ch
);
   import u8s_pkg::*;

   byte_list_type         bytes_ff, bytes_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  present_ff, present_in;
   logic                  last_ff, last_in;
   logic                  pop;

   assign pop  = rsp_ch.valid && rsp_ch.ready;
   assign free = (count_ff == '0) || ((count_ff == CountWidth'(1)) && rsp_ch.ready);

   always_comb begin
      bytes_in   = bytes_ff;
      count_in   = count_ff;
      present_in = present_ff;
      last_in    = last_ff;
      if (pop) begin
         bytes_in = {{ByteWidth{1'b0}}, bytes_ff[MaxResults-1:1]};
         count_in = count_ff - CountWidth'(1);
      end
      if (ld_valid) begin
         bytes_in   = ld.bytes;
         count_in   = ld.count;
         present_in = ld.present;
         last_in    = ld.last;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      if (reset) begin
         count_ff   <= '0;
         present_ff <= 1'b0;
         last_ff    <= 1'b0;
      end else begin
         count_ff   <= count_in;
         present_ff <= present_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_ch.valid        = (count_ff != '0);
   assign rsp_ch.out_byte     = bytes_ff[0];
   assign rsp_ch.byte_present = present_ff;
   assign rsp_ch.run_end      = (count_ff == CountWidth'(1));
   assign rsp_ch.string_done  = (count_ff == CountWidth'(1)) && last_ff;

   `U8S_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CountWidth'(MaxResults), "result count above buffer depth")
   `U8S_ASSERT_IMPLIES(a_bare_marker_alone, clock, reset, (count_ff != '0) && !present_ff, count_ff == CountWidth'(1), "bare end marker shares a run")
   `U8S_ASSERT_NEXT(a_drain_empties, clock, reset, pop && (count_ff == CountWidth'(1)) && !ld_valid, count_ff == '0, "buffer not empty after final pop")

endmodule

// ----- design/utf8_sanitizer_with_budget.sv -----
// top level of the utf8 sanitiser with output byte budget
//
// utf8 sanitiser: one raw string byte per req item, one cleaned byte per rsp item.
// NUL and every rejected sequence lead (bad lead, broken continuation, truncated
// at string end, overlong, surrogate, above 10FFFF) become EF BF BD; the bytes
// after a rejected lead are judged again. An incomplete sequence is held (up to
// three bytes) and produces nothing until it can be judged. Once the next
// emission would exceed max_output_bytes, output stops until the string ends.
// The final item of a string always yields at least one rsp item (a bare end
// marker with byte_present low when nothing else comes out), flagged with
// string_done; counters, held bytes and the stop flag then clear.
// Timing: an item passes an input register, is judged combinationally and its
// results (0 to 12 bytes) land in a result buffer that drains one byte a cycle
// while rsp ready is high; a new item is taken while the previous item's last
// result is being handed out. No clearing pass after reset. csr writes are
// always accepted and apply from the next item on.
`include "utf8_sanitizer_with_budget_macros.svh"

module utf8_sanitizer_with_budget (
   input  logic      clock,
   input  logic      reset,
   u8s_csr_if.sink   csr_ch,
   u8s_req_if.sink   req_ch,
   u8s_rsp_if.source rsp_ch
);
   import u8s_pkg::*;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff, in_byte_in;
   logic                 in_last_ff, in_last_in;

   // budget register
   logic [CfgWidth-1:0] max_ff, max_in;

   // per string state
   logic [HeldDepth-1:0][ByteWidth-1:0] held_ff, held_in;
   logic [1:0]                          held_count_ff, held_count_in;
   logic [CfgWidth-1:0]                 emitted_ff, emitted_in;
   logic                                stopped_ff, stopped_in;

   // byte queue: held bytes followed by the new byte
   logic [QDepth-1:0][ByteWidth-1:0]     q;
   logic [2*QDepth-2:0][ByteWidth-1:0]   qx;
   logic [2:0]                           n;
   logic [QDepth-1:0][QDepth-1:0][ByteWidth-1:0] win;
   logic [QDepth-1:0][2:0]               avail;
   judge_type [QDepth-1:0]               jdg;

   // walk over the queue
   logic [2:0]                          pos;
   logic [CountWidth-1:0]               cnt;
   logic                                done;
   logic                                stop;
   logic                                hold;
   logic [1:0]                          hold_count;
   logic [HeldDepth-1:0][ByteWidth-1:0] hold_bytes;
   byte_list_type                       list;
   judge_type                           jd;
   logic [QDepth-1:0][ByteWidth-1:0]    emit_bytes;
   logic [2:0]                          k;
   logic [2:0]                          adv;
   logic [CountWidth-1:0]               slot;
   logic [CfgWidth:0]                   room;
   logic                                over;

   load_type ld;
   logic     ld_valid;
   logic     buf_free;
   logic     advance;

   // queue build; entries past n are don't care
   always_comb begin
      q = '0;
      for (int i = 0; i < HeldDepth; i++) begin
         q[i] = held_ff[i];
      end
      q[held_count_ff] = in_byte_ff;
      qx = '0;
      qx[QDepth-1:0] = q;
      // once stopped, the rest of the string is dropped
      n = stopped_ff ? 3'd0 : 3'({1'b0, held_count_ff}) + 3'd1;
   end

   // one judge per queue position, all in parallel
   for (genvar p = 0; p < QDepth; p++) begin : g_judge
      assign win[p]   = qx[p+QDepth-1:p];
      assign avail[p] = (n > 3'(p)) ? (n - 3'(p)) : 3'd1;

      u8s_judge u_judge (
         .win   (win[p]),
         .avail (avail[p]),
         .last  (in_last_ff),
         .jd    (jdg[p])
      );
   end

   // budget headroom, worked out once per item
   assign room = {1'b0, max_ff} - {1'b0, emitted_ff};
   assign over = room[CfgWidth];

   // chain the judgements: each step emits and moves on, holds, or hits the budget
   always_comb begin
      pos        = '0;
      cnt        = '0;
      done       = 1'b0;
      stop       = 1'b0;
      hold       = 1'b0;
      hold_count = '0;
      hold_bytes = '0;
      list       = '0;
      jd         = jdg[0];
      emit_bytes = '0;
      k          = '0;
      adv        = '0;
      slot       = '0;
      for (int s = 0; s < QDepth; s++) begin
         jd         = jdg[pos[1:0]];
         emit_bytes = win[pos[1:0]];
         k          = jd.len;
         adv        = jd.len;
         unique case (jd.kind)
            JUDGE_ASCII: begin
               k   = 3'd1;
               adv = 3'd1;
            end
            JUDGE_REPL: begin
               emit_bytes = {{ByteWidth{1'b0}}, ReplByte2, ReplByte1, ReplByte0};
               k          = 3'd3;
               adv        = 3'd1;
            end
            default: begin
            end
         endcase
         if (!done && (pos < n)) begin
            if (jd.kind == JUDGE_HOLD) begin
               hold       = 1'b1;
               hold_count = avail[pos[1:0]][1:0];
               hold_bytes = win[pos[1:0]][HeldDepth-1:0];
               done       = 1'b1;
            end else if (over || (CfgWidth'(5'(cnt) + 5'(k)) > room[CfgWidth-1:0])) begin
               stop = 1'b1;
               done = 1'b1;
            end else begin
               for (int j = 0; j < QDepth; j++) begin
                  if (3'(j) < k) begin
                     slot = cnt + CountWidth'(j);
                     if (slot < CountWidth'(MaxResults)) begin
                        list[slot] = emit_bytes[j];
                     end
                  end
               end
               cnt = cnt + CountWidth'(k);
               pos = pos + adv;
            end
         end
      end
   end

   // what goes to the result buffer
   always_comb begin
      ld.last = in_last_ff;
      if (in_last_ff && (cnt == '0)) begin
         ld.bytes   = '0;
         ld.count   = CountWidth'(1);
         ld.present = 1'b0;
      end else begin
         ld.bytes   = list;
         ld.count   = cnt;
         ld.present = 1'b1;
      end
   end

   // an item with no results need not wait for the buffer
   assign advance  = in_valid_ff && (buf_free || (ld.count == '0));
   assign ld_valid = advance && (ld.count != '0);

   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      in_last_in    = in_last_ff;
      max_in        = max_ff;
      held_in       = held_ff;
      held_count_in = held_count_ff;
      emitted_in    = emitted_ff;
      stopped_in    = stopped_ff;

      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_ch.in_byte;
         in_last_in  = req_ch.last_of_string;
      end

      if (csr_ch.valid && csr_ch.ready) begin
         max_in = csr_ch.max_output_bytes;
      end

      if (advance) begin
         if (in_last_ff) begin
            // string end clears everything
            held_count_in = '0;
            emitted_in    = '0;
            stopped_in    = 1'b0;
         end else begin
            held_count_in = hold ? hold_count : 2'd0;
            emitted_in    = emitted_ff + CfgWidth'(cnt);
            stopped_in    = stopped_ff || stop;
            if (hold) begin
               held_in = hold_bytes;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      held_ff    <= held_in;
      if (reset) begin
         in_valid_ff   <= 1'b0;
         max_ff        <= BudgetReset;
         held_count_ff <= '0;
         emitted_ff    <= '0;
         stopped_ff    <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         max_ff        <= max_in;
         held_count_ff <= held_count_in;
         emitted_ff    <= emitted_in;
         stopped_ff    <= stopped_in;
      end
   end

   u8s_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .ld_valid (ld_valid),
      .ld       (ld),
      .free     (buf_free),
      .rsp_ch   (rsp_ch)
   );

   `U8S_ASSERT_IMPLIES(a_stop_no_hold, clock, reset, stopped_ff, held_count_ff == '0, "bytes held after budget stop")
   `U8S_ASSERT_NEXT(a_string_end_clears, clock, reset, advance && in_last_ff, (held_count_ff == '0) && (emitted_ff == '0) && !stopped_ff, "state not cleared at string end")
   `U8S_ASSERT_IMPLIES(a_load_when_free, clock, reset, ld_valid, buf_free, "result buffer overwritten")

endmodule
